// ----- hw/rtl/rlr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared constants and the request type for the learned-reuse replacement engine.
// ----------------------------------------------------------------------------
package rlr_pkg;
    localparam int NUM_SETS_DEF = 8192;
    localparam int NUM_WAYS_DEF = 16;
    localparam int AGE_BITS_DEF = 8;
    localparam int SET_W        = 13;
    localparam int WAY_W        = 4;
    localparam int SUM_W        = 13;
    localparam int TALLY_W      = 5;
    localparam int REUSE_W      = 9;
    localparam int BONUS_REUSE  = 8;
    localparam int TALLY_LIMIT  = 31;
    localparam int REUSE_SHIFT  = 4;
    localparam int SCORE_START  = 20;
    localparam int SCORE_W      = 5;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way;
        logic       hit;
        logic       pf;
    } t_req;
endpackage

// ----- hw/rtl/rlr_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_store
// Set-wide line state memory: one row per set, one read and one write port,
// registered read data, sweep clear after reset.
// ----------------------------------------------------------------------------
module rlr_store #(
    parameter int NUM_SETS = rlr_pkg::NUM_SETS_DEF,
    parameter int ROW_W    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] i_rd_addr,
    output logic [ROW_W-1:0]            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]            i_wr_data,
    output logic                        o_clr_busy
);
    localparam int AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    logic [ROW_W-1:0] r_mem [NUM_SETS];
    logic [AW-1:0]    r_clr;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_clr == AW'(NUM_SETS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_clr_busy = r_busy;
endmodule

// ----- hw/rtl/rlr_cache_replacement_policy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlr_cache_replacement_policy
// Learned-reuse last-level cache replacement engine.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one request per beat: op 0 queries the
//   victim way of a set, op 1 updates a set after a hit or fill. A query
//   returns one beat on m_axis with the victim way; an update returns none.
//   One request is in flight at a time: the set's row is read from the
//   state memory, then scored or modified (updates write back here), and
//   for a query the output register is then loaded.
//   Scoring is a compare tree over NUM_WAYS ways on the registered read row.
//   After reset a clearing pass writes zero to every set while
//   s_axis_tready stays low.
//   The result sits in an output register; while m_axis is stalled the
//   next request is still taken and read, and a query waits only to present.
// ----------------------------------------------------------------------------
module rlr_cache_replacement_policy #(
    parameter int NUM_SETS = rlr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = rlr_pkg::NUM_WAYS_DEF,
    parameter int AGE_BITS = rlr_pkg::AGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // set_index[12:0], way[16:13], hit[17], pf[18]
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // victim_way[3:0]
);
    localparam int AW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_W   = rlr_pkg::SET_W;
    localparam int SUM_W   = AGE_BITS + rlr_pkg::TALLY_W;
    localparam int REUSE_W = SUM_W - rlr_pkg::REUSE_SHIFT;
    localparam int LINE_W  = AGE_BITS + 2 + SUM_W + rlr_pkg::TALLY_W + REUSE_W;
    localparam int ROW_W   = LINE_W * NUM_WAYS;
    localparam int NP      = 1 << $clog2(NUM_WAYS);
    localparam int RCP_SH  = 30;
    localparam logic [30:0] RCP_M =
        31'(((64'd1 << RCP_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
    localparam logic [SET_W-1:0] SETS_LO  = SET_W'(NUM_SETS);
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef struct packed {
        logic [AGE_BITS-1:0]        age;
        logic                       hf;
        logic                       pf;
        logic [SUM_W-1:0]           sum;
        logic [rlr_pkg::TALLY_W-1:0] tally;
        logic [REUSE_W-1:0]         reuse;
    } t_line;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WORK, S_OUT} t_state;

    t_state         r_state;
    rlr_pkg::t_req  r_req;
    logic [AW-1:0]  r_set;
    logic           r_ovalid;
    logic [rlr_pkg::WAY_W-1:0] r_victim;
    logic [ROW_W-1:0] rd_row, wr_row;
    logic           clr_busy, wr_en;
    t_line          lines [NUM_WAYS];
    t_line          nl    [NUM_WAYS];
    logic [rlr_pkg::WAY_W-1:0] victim;
    logic [rlr_pkg::SCORE_W-1:0] tr_sc  [2*NP];
    logic [AGE_BITS-1:0]         tr_age [2*NP];
    logic [rlr_pkg::WAY_W-1:0]   tr_way [2*NP];
    logic [SET_W-1:0] in_set, set_mod, quo;
    logic [SET_W+30:0] q_prod;

    rlr_store #(.NUM_SETS(NUM_SETS), .ROW_W(ROW_W)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_set),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (wr_row),
        .o_clr_busy(clr_busy)
    );

    // set index modulo NUM_SETS
    assign in_set = s_axis_tdata[SET_W-1:0];
    always_comb begin
        q_prod = (SET_W+31)'(in_set) * (SET_W+31)'(RCP_M);
        quo    = SET_W'(q_prod >> RCP_SH);
        if (NUM_SETS >= (1 << SET_W)) begin
            set_mod = in_set;
        end else if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin
            set_mod = in_set & SET_MASK;
        end else begin
            set_mod = in_set - quo * SETS_LO;
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            lines[w] = t_line'(rd_row[w*LINE_W +: LINE_W]);
        end
    end

    // update path
    always_comb begin
        logic [SUM_W-1:0]            s;
        logic [rlr_pkg::TALLY_W:0]   t;
        for (int w = 0; w < NUM_WAYS; w++) begin
            nl[w] = lines[w];
            s = '0;
            t = '0;
            if (w == int'(r_req.way)) begin
                if (r_req.hit) begin
                    nl[w].hf = 1'b1;
                    if (r_req.pf) nl[w].pf = 1'b1;
                    s = lines[w].sum + SUM_W'(lines[w].age);
                    t = {1'b0, lines[w].tally} + 1'b1;
                    if (t > (rlr_pkg::TALLY_W+1)'(rlr_pkg::TALLY_LIMIT)) begin
                        nl[w].reuse = REUSE_W'(s >> rlr_pkg::REUSE_SHIFT);
                        nl[w].sum   = '0;
                        nl[w].tally = '0;
                    end else begin
                        nl[w].sum   = s;
                        nl[w].tally = t[rlr_pkg::TALLY_W-1:0];
                    end
                end
                nl[w].age = '0;
            end else if (lines[w].age < AGE_MAX) begin
                nl[w].age = lines[w].age + 1'b1;
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            wr_row[w*LINE_W +: LINE_W] = nl[w];
        end
    end

    // victim compare tree: lowest score, then lowest age, then lowest way
    always_comb begin
        logic [rlr_pkg::SCORE_W-1:0] sc;
        for (int i = 0; i < 2*NP; i++) begin
            tr_sc[i]  = '1;
            tr_age[i] = '1;
            tr_way[i] = '0;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            sc = '0;
            if (REUSE_W'(lines[w].age) <= lines[w].reuse)
                sc = sc + rlr_pkg::SCORE_W'(rlr_pkg::BONUS_REUSE);
            if (lines[w].hf) sc = sc + 1'b1;
            if (!lines[w].pf) sc = sc + 1'b1;
            tr_sc[NP+w]  = sc;
            tr_age[NP+w] = lines[w].age;
            tr_way[NP+w] = rlr_pkg::WAY_W'(w);
        end
        for (int i = NP - 1; i >= 1; i--) begin
            if (tr_sc[2*i+1] < tr_sc[2*i] ||
                (tr_sc[2*i+1] == tr_sc[2*i] && tr_age[2*i+1] < tr_age[2*i])) begin
                tr_sc[i]  = tr_sc[2*i+1];
                tr_age[i] = tr_age[2*i+1];
                tr_way[i] = tr_way[2*i+1];
            end else begin
                tr_sc[i]  = tr_sc[2*i];
                tr_age[i] = tr_age[2*i];
                tr_way[i] = tr_way[2*i];
            end
        end
        victim = tr_way[1];
    end

    assign wr_en = (r_state == S_WORK) && (r_req.op == rlr_pkg::OP_UPDATE)
                 && (int'(r_req.way) < NUM_WAYS);
    assign s_axis_tready = (r_state == S_IDLE) && !clr_busy;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_victim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req <= '{op: s_axis_tuser, set_index: s_axis_tdata[12:0],
                                   way: s_axis_tdata[16:13], hit: s_axis_tdata[17],
                                   pf: s_axis_tdata[18]};
                        r_set <= AW'(set_mod);
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_WORK;
                S_WORK: begin
                    if (r_req.op == rlr_pkg::OP_QUERY) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_victim <= victim;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the learned-reuse replacement engine: directed
// table of requests, then random traffic focused on a few hot sets, with
// random idling on both streams and one long output stall. Victim beats are
// compared against an in-bench scoreboard model of the per-line state.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int SETS      = rlr_pkg::NUM_SETS_DEF;
    localparam int WAYS      = rlr_pkg::NUM_WAYS_DEF;
    localparam int AGE_TOP   = (1 << rlr_pkg::AGE_BITS_DEF) - 1;
    localparam int N_RANDOM  = 650;
    localparam int CYCLE_CAP = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // set_index[12:0], way[16:13], hit[17], pf[18]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // victim_way[3:0]

    rlr_cache_replacement_policy DUT (.*);

    always #10 i_clk = ~i_clk;

    // line state, keyed by set*WAYS+way; absent entries are all zero
    typedef struct {
        logic [7:0]       age;
        logic             hit_flag;
        logic             pf_flag;
        logic [rlr_pkg::SUM_W-1:0]   age_sum;
        logic [rlr_pkg::TALLY_W-1:0] tally;
        logic [rlr_pkg::REUSE_W-1:0] reuse;
    } t_line;

    t_line      lines [int];
    logic [3:0] victim_q [$];
    int         n_errors = 0;
    int         n_queries = 0;
    int         n_updates = 0;
    int         cycles = 0;
    bit         stall_out = 1'b0;
    bit         quiet = 1'b0;

    function automatic t_line get_line(int k);
        t_line z;
        z = '{default: '0};
        if (lines.exists(k)) return lines[k];
        return z;
    endfunction

    function automatic logic [3:0] choose_victim(int set);
        int    best_score;
        int    best;
        int    s;
        t_line l;
        t_line b;
        best_score = rlr_pkg::SCORE_START;
        best = 0;
        for (int w = 0; w < WAYS; w++) begin
            l = get_line(set * WAYS + w);
            b = get_line(set * WAYS + best);
            s = 0;
            if (l.age <= l.reuse) s += rlr_pkg::BONUS_REUSE;
            if (l.hit_flag) s += 1;
            if (!l.pf_flag) s += 1;
            if (s < best_score) begin
                best_score = s;
                best = w;
            end else if (s == best_score && l.age < b.age) begin
                best = w;
            end
        end
        return best[3:0];
    endfunction

    task automatic touch_line(int set, int way, bit hit, bit pf);
        t_line l;
        int    k;
        int    t;
        if (way >= WAYS) return;
        if (hit) begin
            k = set * WAYS + way;
            l = get_line(k);
            l.hit_flag = 1'b1;
            if (pf) l.pf_flag = 1'b1;
            l.age_sum = l.age_sum + rlr_pkg::SUM_W'(l.age);
            t = int'(l.tally) + 1;
            if (t > rlr_pkg::TALLY_LIMIT) begin
                l.reuse = rlr_pkg::REUSE_W'(l.age_sum >> rlr_pkg::REUSE_SHIFT);
                l.age_sum = '0;
                l.tally = '0;
            end else begin
                l.tally = rlr_pkg::TALLY_W'(t);
            end
            lines[k] = l;
        end
        for (int w = 0; w < WAYS; w++) begin
            k = set * WAYS + w;
            l = get_line(k);
            if (w == way) l.age = '0;
            else if (l.age < AGE_TOP) l.age = l.age + 8'd1;
            lines[k] = l;
        end
    endtask

    task automatic report(string what, int got, int want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic send(logic op, int set, int way, bit hit, bit pf, int want);
        int s;
        if (!quiet && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (!quiet && $urandom_range(99) < 14);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, pf, hit, way[3:0], set[12:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        s = set % SETS;
        if (op == rlr_pkg::OP_QUERY) begin
            victim_q.push_back(choose_victim(s));
            if (want >= 0 && choose_victim(s) != want) report("table", choose_victim(s), want);
            n_queries++;
        end else begin
            touch_line(s, way, hit, pf);
            n_updates++;
        end
    endtask

    // output side
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout");
            $display("end of test: mismatches");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (victim_q.size() == 0) report("unexpected beat", m_axis_tdata, -1);
            else begin
                if (m_axis_tdata != {4'b0, victim_q[0]})
                    report("victim_way", m_axis_tdata, victim_q[0]);
                void'(victim_q.pop_front());
            end
        end
        m_axis_tready <= !stall_out && (quiet || $urandom_range(99) >= 14);
    end

    typedef struct {
        logic op;
        int   set;
        int   way;
        bit   hit;
        bit   pf;
        int   want;
    } t_row;

    t_row dir_tab [] = '{
        '{rlr_pkg::OP_QUERY,  0,    0,  0, 0, 0},
        '{rlr_pkg::OP_QUERY,  8191, 0,  0, 0, 0},
        '{rlr_pkg::OP_UPDATE, 8191, 15, 1, 1, -1},
        '{rlr_pkg::OP_QUERY,  8191, 0,  0, 0, -1},
        '{rlr_pkg::OP_UPDATE, 8191, 0,  0, 0, -1},
        '{rlr_pkg::OP_QUERY,  8191, 0,  0, 0, -1},
        '{rlr_pkg::OP_UPDATE, 0,    5,  1, 0, -1},
        '{rlr_pkg::OP_UPDATE, 0,    5,  1, 1, -1},
        '{rlr_pkg::OP_QUERY,  0,    0,  0, 0, -1},
        '{rlr_pkg::OP_UPDATE, 1,    10, 0, 1, -1},
        '{rlr_pkg::OP_QUERY,  1,    15, 1, 1, -1},
        '{rlr_pkg::OP_QUERY,  4096, 0,  1, 1, 0}
    };

    int set_pool [4];
    int s_sel;

    initial begin
        quiet = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tab[i])
            send(dir_tab[i].op, dir_tab[i].set, dir_tab[i].way, dir_tab[i].hit,
                 dir_tab[i].pf, dir_tab[i].want);
        // drive one line past its hit-tally limit so the reuse estimate loads
        for (int i = 0; i < 40; i++) begin
            send(rlr_pkg::OP_UPDATE, 2, 3, 1, i[0], -1);
            send(rlr_pkg::OP_UPDATE, 2, 7 + (i % 4), 1'($urandom_range(1)), 0, -1);
            if (i % 8 == 0) send(rlr_pkg::OP_QUERY, 2, 0, 0, 0, -1);
        end
        foreach (set_pool[i]) set_pool[i] = $urandom_range(SETS - 1);
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= 250 && i < 400);
            if (i == 450) fork
                begin
                    stall_out = 1'b1;
                    repeat (300) @(posedge i_clk);
                    stall_out = 1'b0;
                end
            join_none
            s_sel = ($urandom_range(9) < 8) ? set_pool[$urandom_range(3)]
                                            : $urandom_range(SETS - 1);
            send($urandom_range(99) < 40 ? rlr_pkg::OP_QUERY : rlr_pkg::OP_UPDATE, s_sel,
                 $urandom_range(15), $urandom_range(99) < 70, 1'($urandom_range(1)), -1);
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d victim queries and %0d set updates, hot and cold sets",
                 n_queries, n_updates);
        if (n_errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/rlr_pkg.sv
hw/rtl/rlr_store.sv
hw/rtl/rlr_cache_replacement_policy.sv
tb/tb_top.sv
